>>> sv/f2r50_pkg.sv
// package for the radix-50 file name encoder: result and status types,
// phase codes, character map and word arithmetic; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package f2r50_pkg;

    localparam int unsigned CHAR_W = 8;
    localparam int unsigned WORD_W = 16;
    localparam int unsigned CODE_W = 6;
    localparam int unsigned POS_W  = 3;

    localparam logic [CHAR_W-1:0] CH_END    = 8'h00;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UC_A   = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UC_Z   = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LC_A   = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LC_Z   = 8'h7A;

    localparam logic [CHAR_W-1:0] R50_SPACE  = 8'd0;
    localparam logic [CHAR_W-1:0] R50_DOLLAR = 8'o33;
    localparam logic [CHAR_W-1:0] R50_DOT    = 8'o34;
    localparam logic [CHAR_W-1:0] R50_DIGIT0 = 8'o36;
    localparam logic [CHAR_W-1:0] R50_LETTER = 8'd1;
    localparam logic [CHAR_W-1:0] R50_BAD    = 8'd255;

    localparam logic [WORD_W-1:0] R50_BASE = 16'o50;
    localparam logic [WORD_W-1:0] R50_SQ   = 16'd1600;
    localparam logic [WORD_W-1:0] R50_CUBE = 16'd64000;

    localparam logic [POS_W-1:0] NAME_HALF = 3'd3;
    localparam logic [POS_W-1:0] NAME_LEN  = 3'd6;
    localparam logic [POS_W-1:0] EXT_LEN   = 3'd3;

    typedef enum logic [3:0] {
        PH_NAME = 4'b0001,
        PH_DOT  = 4'b0010,
        PH_EXT  = 4'b0100,
        PH_FULL = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [WORD_W-1:0] name_word_a;
        logic [WORD_W-1:0] name_word_b;
        logic [WORD_W-1:0] ext_word;
        logic              ok;
    } result_t;

    typedef struct packed {
        logic done;
        logic clear;
    } status_t;

    function automatic logic [CHAR_W-1:0] char_code(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        r = R50_BAD;
        if (c == CH_SPACE) begin
            r = R50_SPACE;
        end else if (c == CH_DOLLAR) begin
            r = R50_DOLLAR;
        end else if (c == CH_DOT) begin
            r = R50_DOT;
        end else if (c >= CH_ZERO && c <= CH_NINE) begin
            r = c - CH_ZERO + R50_DIGIT0;
        end else if (c >= CH_UC_A && c <= CH_UC_Z) begin
            r = c - CH_UC_A + R50_LETTER;
        end else if (c >= CH_LC_A && c <= CH_LC_Z) begin
            r = c - CH_LC_A + R50_LETTER;
        end
        return r;
    endfunction

    // acc * 40 + code, kept to one word
    function automatic logic [WORD_W-1:0] mac(input logic [WORD_W-1:0] v,
                                              input logic [CODE_W-1:0] code);
        logic [2*WORD_W-1:0] prod;
        prod = {{WORD_W{1'b0}}, v} * {{WORD_W{1'b0}}, R50_BASE}
             + {{(2*WORD_W-CODE_W){1'b0}}, code};
        return prod[WORD_W-1:0];
    endfunction

    // pad with k spaces: acc * 40^k, kept to one word
    function automatic logic [WORD_W-1:0] pad(input logic [WORD_W-1:0] v,
                                              input logic [1:0] k);
        logic [WORD_W-1:0]   f;
        logic [2*WORD_W-1:0] prod;
        case (k)
            2'd0:    f = 16'd1;
            2'd1:    f = R50_BASE;
            2'd2:    f = R50_SQ;
            2'd3:    f = R50_CUBE;
            default: f = 16'd1;
        endcase
        prod = {{WORD_W{1'b0}}, v} * {{WORD_W{1'b0}}, f};
        return prod[WORD_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> sv/f2r50_core.sv
// packing state and per-character update for the radix-50 encoder
// depends on f2r50_pkg
`timescale 1ns / 1ps
`default_nettype none

module f2r50_core (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        step,
    input  wire logic [f2r50_pkg::CHAR_W-1:0] ch,
    output f2r50_pkg::result_t               res,
    output f2r50_pkg::status_t               status
);

    f2r50_pkg::phase_t                  phase_reg, phase_next;
    logic [f2r50_pkg::POS_W-1:0]        pos_reg, pos_next;
    logic [f2r50_pkg::WORD_W-1:0]       acc_a_reg, acc_a_next;
    logic [f2r50_pkg::WORD_W-1:0]       acc_b_reg, acc_b_next;
    logic [f2r50_pkg::WORD_W-1:0]       acc_ext_reg, acc_ext_next;
    logic                               failed_reg, failed_next;

    logic [f2r50_pkg::CHAR_W-1:0]       code;
    logic                               bad;
    logic [f2r50_pkg::CODE_W-1:0]       code6;
    logic [1:0]                         k_a, k_b, k_ext;
    logic [f2r50_pkg::WORD_W-1:0]       pad_a, pad_b, pad_ext;
    logic [f2r50_pkg::POS_W-1:0]        pos_inc;

    assign code    = f2r50_pkg::char_code(ch);
    assign bad     = (code == f2r50_pkg::R50_BAD);
    assign code6   = code[f2r50_pkg::CODE_W-1:0];
    assign pos_inc = pos_reg + 3'd1;

    // spaces still missing in each word
    assign k_a   = (pos_reg < f2r50_pkg::NAME_HALF) ?
                   2'(f2r50_pkg::NAME_HALF - pos_reg) : 2'd0;
    assign k_b   = (pos_reg >= f2r50_pkg::NAME_HALF && pos_reg < f2r50_pkg::NAME_LEN) ?
                   2'(f2r50_pkg::NAME_LEN - pos_reg) : 2'd0;
    assign k_ext = (pos_reg < f2r50_pkg::EXT_LEN) ?
                   2'(f2r50_pkg::EXT_LEN - pos_reg) : 2'd0;

    assign pad_a   = f2r50_pkg::pad(acc_a_reg, k_a);
    assign pad_b   = f2r50_pkg::pad(acc_b_reg, k_b);
    assign pad_ext = f2r50_pkg::pad(acc_ext_reg, k_ext);

    always_comb begin
        res.name_word_a = acc_a_reg;
        res.name_word_b = acc_b_reg;
        res.ext_word    = acc_ext_reg;
        res.ok          = !failed_reg;
        if (!failed_reg && phase_reg == f2r50_pkg::PH_NAME) begin
            res.name_word_a = pad_a;
            res.name_word_b = pad_b;
        end
        if (!failed_reg && phase_reg == f2r50_pkg::PH_EXT) begin
            res.ext_word = pad_ext;
        end
    end

    always_comb begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        acc_a_next   = acc_a_reg;
        acc_b_next   = acc_b_reg;
        acc_ext_next = acc_ext_reg;
        failed_next  = failed_reg;
        if (step) begin
            if (ch == f2r50_pkg::CH_END) begin
                phase_next   = f2r50_pkg::PH_NAME;
                pos_next     = '0;
                acc_a_next   = '0;
                acc_b_next   = '0;
                acc_ext_next = '0;
                failed_next  = 1'b0;
            end else if (!failed_reg) begin
                case (phase_reg)
                    f2r50_pkg::PH_NAME: begin
                        if (ch == f2r50_pkg::CH_DOT) begin
                            acc_a_next = pad_a;
                            acc_b_next = pad_b;
                            phase_next = f2r50_pkg::PH_EXT;
                            pos_next   = '0;
                        end else if (bad) begin
                            failed_next = 1'b1;
                        end else begin
                            if (pos_reg < f2r50_pkg::NAME_HALF) begin
                                acc_a_next = f2r50_pkg::mac(acc_a_reg, code6);
                            end else begin
                                acc_b_next = f2r50_pkg::mac(acc_b_reg, code6);
                            end
                            if (pos_inc >= f2r50_pkg::NAME_LEN) begin
                                phase_next = f2r50_pkg::PH_DOT;
                                pos_next   = '0;
                            end else begin
                                pos_next = pos_inc;
                            end
                        end
                    end
                    f2r50_pkg::PH_DOT: begin
                        // one dot after a full name is skipped
                        phase_next = f2r50_pkg::PH_EXT;
                        pos_next   = '0;
                        if (ch != f2r50_pkg::CH_DOT) begin
                            if (bad) begin
                                failed_next = 1'b1;
                            end else begin
                                acc_ext_next = f2r50_pkg::mac(acc_ext_reg, code6);
                                pos_next     = 3'd1;
                            end
                        end
                    end
                    f2r50_pkg::PH_EXT: begin
                        if (bad) begin
                            failed_next = 1'b1;
                        end else begin
                            acc_ext_next = f2r50_pkg::mac(acc_ext_reg, code6);
                            if (pos_inc >= f2r50_pkg::EXT_LEN) begin
                                phase_next = f2r50_pkg::PH_FULL;
                                pos_next   = '0;
                            end else begin
                                pos_next = pos_inc;
                            end
                        end
                    end
                    default: begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= f2r50_pkg::PH_NAME;
            pos_reg     <= '0;
            acc_a_reg   <= '0;
            acc_b_reg   <= '0;
            acc_ext_reg <= '0;
            failed_reg  <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            acc_a_reg   <= acc_a_next;
            acc_b_reg   <= acc_b_next;
            acc_ext_reg <= acc_ext_next;
            failed_reg  <= failed_next;
        end
    end

    assign status.done  = step && (ch == f2r50_pkg::CH_END);
    assign status.clear = (phase_reg == f2r50_pkg::PH_NAME) && (pos_reg == '0)
                          && !failed_reg && (acc_a_reg == '0) && (acc_b_reg == '0)
                          && (acc_ext_reg == '0);

endmodule

`default_nettype wire

>>> sv/filename_to_rad50_encoder_unit.sv
// top level of the radix-50 file name encoder: input register, packer core,
// result register and stream handshake; depends on f2r50_pkg and f2r50_core
//
// channel   dir  tdata                            tuser
// s_        in   [7:0] ch                         -
// m_        out  [15:0] name_word_a,              [0] ok
//                [31:16] name_word_b,
//                [47:32] ext_word
//
// one character item per cycle while no result is stalled; an item enters the
// input register, is folded into the accumulators once the core steps,
// and the 0 byte loads the result register and raises m_tvalid
// a stalled result holds a full input register; items keep flowing otherwise
// aresetn clears the handshake state and the packing state at once
`timescale 1ns / 1ps
`default_nettype none

module filename_to_rad50_encoder_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // ch
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // name_word_a, name_word_b, ext_word
    output logic             m_tuser    // ok
);

    logic                             in_valid_reg;
    logic [f2r50_pkg::CHAR_W-1:0]     in_ch_reg;
    logic                             out_valid_reg, out_valid_next;
    f2r50_pkg::result_t               out_reg;
    f2r50_pkg::result_t               res;
    f2r50_pkg::status_t               status;
    logic                             step;

    // the core advances on a full input register unless a result sits unaccepted
    assign step     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;

    f2r50_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .ch      (in_ch_reg),
        .res     (res),
        .status  (status)
    );

    always_comb begin
        out_valid_next = out_valid_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (status.done) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_ch_reg <= s_tdata;
        end
        if (status.done) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.ext_word, out_reg.name_word_b, out_reg.name_word_a};
    assign m_tuser  = out_reg.ok;

    // a new result only ever comes from an end-of-name byte
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !$past(out_valid_reg)) |-> $past(status.done))
        else $error("result appeared without an end byte");

    // packing state returns to reset after every result
    a_clear_after_done: assert property (@(posedge aclk) disable iff (!aresetn)
        status.done |=> status.clear)
        else $error("packing state not cleared after result");

    // a stalled result blocks the core
    a_no_step_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |-> !step)
        else $error("core advanced while result stalled");

    // a full input register with a stalled result takes nothing
    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_tready) |=> $stable(in_ch_reg))
        else $error("input item lost under stall");

endmodule

`default_nettype wire
